FILE: sv/igf_pkg.sv
// igf_pkg: shared types and constants of the interval gap finder
package igf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	// what one queue entry asks the back part to emit
	typedef struct packed {
		logic has_gap;    // gap in front of a held interval
		logic has_tail;   // closing result of the query
		logic tail_valid; // closing result holds a gap, not an end marker
	} igf_flags_t;

endpackage

FILE: sv/igf_front.sv
// igf_front: accepts items, tracks cursor and request end, classifies results
module igf_front #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_op,
	input  logic [OFFSET_BITS-1:0] in_start,
	input  logic [OFFSET_BITS-1:0] in_end,
	input  logic                   in_last,
	input  logic                   q_full,
	output logic                   q_push,
	output igf_pkg::igf_flags_t    q_flags,
	output logic [OFFSET_BITS-1:0] q_gap_start,
	output logic [OFFSET_BITS-1:0] q_gap_end,
	output logic [OFFSET_BITS-1:0] q_tail_start,
	output logic [OFFSET_BITS-1:0] q_tail_end
);

	localparam logic OP_REQUEST = 1'b0;

	logic [OFFSET_BITS:0]   cursor_q, cursor_n, start_x, after;
	logic [OFFSET_BITS-1:0] req_end_q, req_end_n;
	logic                   past_q, past_n;
	logic                   accept, gap_hit, tail_valid;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		start_x   = {1'b0, in_start};
		after     = {1'b0, in_end} + {{OFFSET_BITS{1'b0}}, 1'b1};
		cursor_n  = cursor_q;
		req_end_n = req_end_q;
		past_n    = past_q;
		gap_hit   = 1'b0;
		if (in_op == OP_REQUEST) begin
			cursor_n  = start_x;
			req_end_n = in_end;
			past_n    = 1'b0;
		end else if (!past_q) begin
			if (in_start > req_end_q) begin
				past_n = 1'b1;
			end else begin
				gap_hit = cursor_q < start_x;
				if (after > cursor_q) begin
					cursor_n = after;
				end
			end
		end
	end

	assign tail_valid   = cursor_n <= {1'b0, req_end_n};
	assign q_push       = accept && (gap_hit || in_last);
	assign q_flags      = '{has_gap: gap_hit, has_tail: in_last, tail_valid: tail_valid};
	assign q_gap_start  = cursor_q[OFFSET_BITS-1:0];
	assign q_gap_end    = in_start - {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	assign q_tail_start = tail_valid ? cursor_n[OFFSET_BITS-1:0] : '0;
	assign q_tail_end   = tail_valid ? req_end_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			req_end_q <= '0;
			past_q    <= 1'b0;
		end else if (accept) begin
			cursor_q  <= cursor_n;
			req_end_q <= req_end_n;
			past_q    <= past_n;
		end
	end

endmodule

FILE: sv/igf_queue.sv
// igf_queue: short first-in first-out queue between front and back
module igf_queue #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/igf_back.sv
// igf_back: expands queue entries into results and holds the output register
module igf_back #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  igf_pkg::igf_flags_t    head_flags,
	input  logic [OFFSET_BITS-1:0] head_gap_start,
	input  logic [OFFSET_BITS-1:0] head_gap_end,
	input  logic [OFFSET_BITS-1:0] head_tail_start,
	input  logic [OFFSET_BITS-1:0] head_tail_end,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OFFSET_BITS-1:0] out_start,
	output logic [OFFSET_BITS-1:0] out_end,
	output logic                   out_gap_valid,
	output logic                   out_last
);

	typedef enum logic {
		PH_FIRST,
		PH_TAIL
	} phase_t;

	phase_t phase_q;
	logic   load, take, two_part, emit_gap;

	assign load     = !out_valid || out_ready;
	assign take     = load && head_valid;
	assign two_part = head_flags.has_gap && head_flags.has_tail;
	assign emit_gap = (phase_q == PH_FIRST) && head_flags.has_gap;
	assign pop      = take && ((phase_q == PH_TAIL) || !two_part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST;
			out_valid     <= 1'b0;
			out_start     <= '0;
			out_end       <= '0;
			out_gap_valid <= 1'b0;
			out_last      <= 1'b0;
		end else if (load) begin
			out_valid <= head_valid;
			if (head_valid) begin
				if (emit_gap) begin
					out_start     <= head_gap_start;
					out_end       <= head_gap_end;
					out_gap_valid <= 1'b1;
					out_last      <= 1'b0;
					phase_q       <= two_part ? PH_TAIL : PH_FIRST;
				end else begin
					out_start     <= head_tail_start;
					out_end       <= head_tail_end;
					out_gap_valid <= head_flags.tail_valid;
					out_last      <= 1'b1;
					phase_q       <= PH_FIRST;
				end
			end
		end
	end

endmodule

FILE: sv/interval_gap_finder.sv
// interval_gap_finder: top level, front classifier, result queue and back emitter
//
// channel  dir  tdata (low bit up)                 tuser        tlast
// s_*      in   range_start, range_end, zero pad   operation    last_item
// m_*      out  gap_start, gap_end, zero pad       gap_valid    last_result
//
// one input transfer per cycle unless the queue is full; each item is classified
// in the cycle it is taken; an item with a gap and the closing result yields two
// results, sent from the back part's output register one per cycle unless stalled
// the queue holds igf_pkg::QUEUE_DEPTH entries; s_tready drops only while it is full
// arst_n clears cursor, request end, past flag, queue pointers and output valid
module interval_gap_finder #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((2*OFFSET_BITS+7)/8)*8-1:0]     s_tdata,  // range_start, range_end
	input  logic                                   s_tuser,  // operation
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*OFFSET_BITS+7)/8)*8-1:0]     m_tdata,  // gap_start, gap_end
	output logic                                   m_tuser,  // gap_valid
	output logic                                   m_tlast
);

	localparam int unsigned TDATA_W = ((2 * OFFSET_BITS + 7) / 8) * 8;
	localparam int unsigned FLAG_W  = $bits(igf_pkg::igf_flags_t);
	localparam int unsigned ENTRY_W = FLAG_W + 4 * OFFSET_BITS;

	igf_pkg::igf_flags_t    push_flags, head_flags;
	logic [OFFSET_BITS-1:0] push_gs, push_ge, push_ts, push_te;
	logic [OFFSET_BITS-1:0] head_gs, head_ge, head_ts, head_te;
	logic [OFFSET_BITS-1:0] out_start, out_end;
	logic [ENTRY_W-1:0]     push_data, head_data;
	logic                   q_push, q_full, q_pop, q_head_valid;

	igf_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.in_start     (s_tdata[OFFSET_BITS-1:0]),
		.in_end       (s_tdata[2*OFFSET_BITS-1:OFFSET_BITS]),
		.in_last      (s_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_flags      (push_flags),
		.q_gap_start  (push_gs),
		.q_gap_end    (push_ge),
		.q_tail_start (push_ts),
		.q_tail_end   (push_te)
	);

	assign push_data = {push_flags, push_gs, push_ge, push_ts, push_te};

	igf_queue #(.DATA_W(ENTRY_W), .DEPTH(igf_pkg::QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (head_data)
	);

	assign {head_flags, head_gs, head_ge, head_ts, head_te} = head_data;

	igf_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (q_head_valid),
		.head_flags      (head_flags),
		.head_gap_start  (head_gs),
		.head_gap_end    (head_ge),
		.head_tail_start (head_ts),
		.head_tail_end   (head_te),
		.pop             (q_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_start       (out_start),
		.out_end         (out_end),
		.out_gap_valid   (m_tuser),
		.out_last        (m_tlast)
	);

	assign m_tdata = TDATA_W'({out_end, out_start});

endmodule

FILE: sv/igf_checker.sv
// igf_checker: port-level assertions for the interval gap finder and its bind
module igf_checker #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [((2*OFFSET_BITS+7)/8)*8-1:0] m_tdata,
	input logic                               m_tuser,
	input logic                               m_tlast
);

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// end marker always closes a query
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("end marker without last_result");

	// end marker carries zero offsets
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("end marker with nonzero offsets");

	// a reported gap is never reversed
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			m_tdata[OFFSET_BITS-1:0] <= m_tdata[2*OFFSET_BITS-1:OFFSET_BITS])
		else $error("gap start above gap end");

endmodule

bind interval_gap_finder igf_checker #(.OFFSET_BITS(OFFSET_BITS)) u_igf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
